### design/epoch_change_journal_top_defines.svh
// Assertion macros shared by the epoch change journal checker.
`ifndef EPOCH_CHANGE_JOURNAL_TOP_DEFINES_SVH
`define EPOCH_CHANGE_JOURNAL_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ECJ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecj check failed");

// Check that cons holds in the cycle after ante.
`define ECJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecj check failed");

`endif

### design/ecj_pkg.sv
// Shared types, constants and helpers of the epoch change journal.
`timescale 1ns / 1ps
`default_nettype none

package ecj_pkg;

  localparam int LOG_DEPTH = 64;
  localparam int SLOT_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int CFG_W     = 7;
  localparam int MAX_W     = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int KEY_W     = 32;
  localparam int EPOCH_W   = 64;
  localparam int STATUS_W  = 3;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RECORDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY_OK = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_NEW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_OLD  = 3'd4;

  typedef struct packed {
    logic signed [KEY_W-1:0] x;
    logic signed [KEY_W-1:0] y;
    logic signed [KEY_W-1:0] z;
    logic                    kind;
    logic [EPOCH_W-1:0]      epoch;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    entry_t              entry;
    logic                last;
  } result_t;

  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(LOG_DEPTH)) begin
      s = s - (CNT_W+1)'(LOG_DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] eff_max(input logic [CFG_W-1:0] cfg);
    logic [MAX_W-1:0] m;
    m = MAX_W'(cfg);
    if (m == '0) begin
      m = MAX_W'(1);
    end else if (m > MAX_W'(LOG_DEPTH)) begin
      m = MAX_W'(LOG_DEPTH);
    end
    return CNT_W'(m);
  endfunction

endpackage

`default_nettype wire

### design/ecj_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ecj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/ecj_out.sv
// Output register stage of the epoch change journal.
`timescale 1ns / 1ps
`default_nettype none

module ecj_out (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire ecj_pkg::result_t res_i,
  input  wire logic            out_stall_i,
  output      logic            free_o,
  output      logic            out_valid_o,
  output      ecj_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  ecj_pkg::result_t res_q, res_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### design/epoch_change_journal_top.sv
// Top level of the epoch change journal: control, epoch state and log RAM.
// Each result is registered in the output stage; a walking query's entries pass first through
// the log RAM read register. A record, a failed query or an empty-ok query gives a single result;
// a walking query reads every stored entry in turn through the single log RAM read port.
// Output stalls hold the walk on a matching entry; a new word is taken only once the walk ends.
// Reset clears the count, oldest slot and epoch counter and sets max_entries to 64.
`timescale 1ns / 1ps
`default_nettype none

module epoch_change_journal_top (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ecj_pkg::CFG_W-1:0]             cfg_wdata_i,
  input  wire logic                                  in_valid_i,
  output      logic                                  in_stall_o,
  input  wire logic                                  command_i,
  input  wire logic signed [ecj_pkg::KEY_W-1:0]      key_x_i,
  input  wire logic signed [ecj_pkg::KEY_W-1:0]      key_y_i,
  input  wire logic signed [ecj_pkg::KEY_W-1:0]      key_z_i,
  input  wire logic                                  change_kind_i,
  input  wire logic [ecj_pkg::EPOCH_W-1:0]           cursor_i,
  output      logic                                  out_valid_o,
  input  wire logic                                  out_stall_i,
  output      logic [ecj_pkg::STATUS_W-1:0]          status_o,
  output      logic signed [ecj_pkg::KEY_W-1:0]      out_x_o,
  output      logic signed [ecj_pkg::KEY_W-1:0]      out_y_o,
  output      logic signed [ecj_pkg::KEY_W-1:0]      out_z_o,
  output      logic                                  out_kind_o,
  output      logic [ecj_pkg::EPOCH_W-1:0]           entry_epoch_o,
  output      logic                                  last_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic                                state_q, state_d;
  logic [ecj_pkg::CFG_W-1:0]           max_q, max_d;
  logic [ecj_pkg::SLOT_W-1:0]          oldest_q, oldest_d;
  logic [ecj_pkg::CNT_W-1:0]           count_q, count_d;
  logic [ecj_pkg::EPOCH_W-1:0]         ctr_q, ctr_d;
  logic [ecj_pkg::CNT_W-1:0]           idx_q, idx_d;
  logic [ecj_pkg::EPOCH_W-1:0]         cursor_q, cursor_d;

  logic                                out_free;
  logic                                out_load;
  ecj_pkg::result_t                    res_in;
  ecj_pkg::result_t                    res_out;

  logic                                ram_we;
  logic [ecj_pkg::SLOT_W-1:0]          ram_waddr;
  ecj_pkg::entry_t                     ram_wdata;
  logic                                ram_re;
  logic [ecj_pkg::SLOT_W-1:0]          ram_raddr;
  logic [ecj_pkg::ENTRY_W-1:0]         ram_rdata;
  ecj_pkg::entry_t                     rd_entry;

  logic                                in_acc;
  logic [ecj_pkg::CNT_W:0]             cnt_inc;
  logic [ecj_pkg::EPOCH_W-1:0]         ctr_inc;
  logic [ecj_pkg::EPOCH_W-1:0]         old_bound;
  logic                                too_new;
  logic                                too_old;
  logic                                no_entries;
  logic                                match;
  logic                                is_last;
  logic [ecj_pkg::CNT_W-1:0]           idx_inc;

  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cnt_inc    = {1'b0, count_q} + (ecj_pkg::CNT_W+1)'(1);
  assign ctr_inc    = ctr_q + ecj_pkg::EPOCH_W'(1);
  assign old_bound  = ctr_q - ecj_pkg::EPOCH_W'(count_q);
  assign too_new    = cursor_i > ctr_q;
  assign too_old    = (count_q != '0) && (cursor_i < old_bound);
  assign no_entries = (count_q == '0) || (cursor_i == ctr_q);

  assign rd_entry   = ecj_pkg::entry_t'(ram_rdata);
  assign match      = rd_entry.epoch > cursor_q;
  assign is_last    = idx_q == (count_q - ecj_pkg::CNT_W'(1));
  assign idx_inc    = idx_q + ecj_pkg::CNT_W'(1);

  always_comb begin
    state_d   = state_q;
    max_d     = max_q;
    oldest_d  = oldest_q;
    count_d   = count_q;
    ctr_d     = ctr_q;
    idx_d     = idx_q;
    cursor_d  = cursor_q;
    out_load  = 1'b0;
    res_in    = '0;
    ram_we    = 1'b0;
    ram_waddr = ecj_pkg::slot_add(oldest_q, count_q);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = oldest_q;

    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (command_i == ecj_pkg::CMD_RECORD) begin
            ram_we          = 1'b1;
            ram_wdata.x     = key_x_i;
            ram_wdata.y     = key_y_i;
            ram_wdata.z     = key_z_i;
            ram_wdata.kind  = change_kind_i;
            ram_wdata.epoch = ctr_inc;
            ctr_d           = ctr_inc;
            if (cnt_inc > {1'b0, ecj_pkg::eff_max(max_q)}) begin
              oldest_d = ecj_pkg::slot_add(oldest_q, ecj_pkg::CNT_W'(1));
            end else begin
              count_d = cnt_inc[ecj_pkg::CNT_W-1:0];
            end
            out_load      = 1'b1;
            res_in.status = ecj_pkg::ST_RECORDED;
            res_in.entry  = ram_wdata;
            res_in.last   = 1'b1;
          end else if (too_new) begin
            out_load      = 1'b1;
            res_in.status = ecj_pkg::ST_TOO_NEW;
            res_in.last   = 1'b1;
          end else if (too_old) begin
            out_load      = 1'b1;
            res_in.status = ecj_pkg::ST_TOO_OLD;
            res_in.last   = 1'b1;
          end else if (no_entries) begin
            out_load      = 1'b1;
            res_in.status = ecj_pkg::ST_EMPTY_OK;
            res_in.last   = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = oldest_q;
            idx_d     = '0;
            cursor_d  = cursor_i;
            state_d   = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (match && out_free) begin
          out_load      = 1'b1;
          res_in.status = ecj_pkg::ST_ENTRY;
          res_in.entry  = rd_entry;
          res_in.last   = is_last;
        end
        if (!match || out_free) begin
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ecj_pkg::slot_add(oldest_q, idx_inc);
            idx_d     = idx_inc;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      max_q    <= ecj_pkg::CFG_RESET;
      oldest_q <= '0;
      count_q  <= '0;
      ctr_q    <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      max_q    <= max_d;
      oldest_q <= oldest_d;
      count_q  <= count_d;
      ctr_q    <= ctr_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
  end

  ecj_ram #(
    .WIDTH (ecj_pkg::ENTRY_W),
    .DEPTH (ecj_pkg::LOG_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ecj_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .res_i       (res_in),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_out)
  );

  assign status_o      = res_out.status;
  assign out_x_o       = res_out.entry.x;
  assign out_y_o       = res_out.entry.y;
  assign out_z_o       = res_out.entry.z;
  assign out_kind_o    = res_out.entry.kind;
  assign entry_epoch_o = res_out.entry.epoch;
  assign last_o        = res_out.last;

endmodule

`default_nettype wire

### design/ecj_checker.sv
// Port-level checker of the epoch change journal and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "epoch_change_journal_top_defines.svh"

module ecj_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  in_valid_i,
  input wire logic                                  in_stall_o,
  input wire logic                                  command_i,
  input wire logic                                  out_valid_o,
  input wire logic                                  out_stall_i,
  input wire logic [ecj_pkg::STATUS_W-1:0]          status_o,
  input wire logic signed [ecj_pkg::KEY_W-1:0]      out_x_o,
  input wire logic signed [ecj_pkg::KEY_W-1:0]      out_y_o,
  input wire logic signed [ecj_pkg::KEY_W-1:0]      out_z_o,
  input wire logic                                  out_kind_o,
  input wire logic [ecj_pkg::EPOCH_W-1:0]           entry_epoch_o,
  input wire logic                                  last_o
);

  `ECJ_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(entry_epoch_o) && $stable(last_o))
  `ECJ_ASSERT_NEXT(a_record_result,
    in_valid_i && !in_stall_o && (command_i == ecj_pkg::CMD_RECORD),
    out_valid_o && (status_o == ecj_pkg::ST_RECORDED) && last_o)
  `ECJ_ASSERT_SAME(a_single_last, out_valid_o && (status_o != ecj_pkg::ST_ENTRY), last_o)
  `ECJ_ASSERT_SAME(a_fail_zero,
    out_valid_o && ((status_o == ecj_pkg::ST_TOO_NEW) || (status_o == ecj_pkg::ST_TOO_OLD)
    || (status_o == ecj_pkg::ST_EMPTY_OK)),
    (entry_epoch_o == '0) && (out_x_o == '0) && (out_y_o == '0) && (out_z_o == '0)
    && !out_kind_o)

endmodule

bind epoch_change_journal_top ecj_checker u_ecj_checker (.*);

`default_nettype wire
